// ----- src/rsncl_pkg.sv -----
package rsncl_pkg;

  localparam int unsigned     MAX_HASHES = 255;
  localparam longint unsigned MAX_DEPTH  = 65535;

  localparam int CpW = 21;

  localparam logic [CpW-1:0] CP_EOF   = 21'h000000;
  localparam logic [CpW-1:0] CP_LF    = 21'h00000A;
  localparam logic [CpW-1:0] CP_FF    = 21'h00000C;
  localparam logic [CpW-1:0] CP_CR    = 21'h00000D;
  localparam logic [CpW-1:0] CP_NEL   = 21'h000085;
  localparam logic [CpW-1:0] CP_LS    = 21'h002028;
  localparam logic [CpW-1:0] CP_PS    = 21'h002029;
  localparam logic [CpW-1:0] CP_HASH  = 21'h000023;
  localparam logic [CpW-1:0] CP_QUOTE = 21'h000022;
  localparam logic [CpW-1:0] CP_STAR  = 21'h00002A;
  localparam logic [CpW-1:0] CP_SLASH = 21'h00002F;

  localparam int MaskEnd     = 0;
  localparam int MaskComment = 1;
  localparam int MaskRaw     = 2;

  typedef enum logic [3:0] {
    M_IDLE        = 4'd0,
    M_C_OPEN      = 4'd1,
    M_C_BODY      = 4'd2,
    M_C_SLASH     = 4'd3,
    M_R_HASH      = 4'd4,
    M_R_Q1        = 4'd5,
    M_R_Q2        = 4'd6,
    M_R_EMPTY     = 4'd7,
    M_R_ML_NL     = 4'd8,
    M_R_SL        = 4'd9,
    M_R_SL_CLOSE  = 4'd10,
    M_R_ML        = 4'd11,
    M_R_ML_QUOTES = 4'd12,
    M_R_ML_CLOSE  = 4'd13
  } scan_mode_e;

  typedef enum logic [1:0] {
    ST_CONT   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    TK_END     = 2'd0,
    TK_COMMENT = 2'd1,
    TK_RAW     = 2'd2
  } token_kind_e;

  typedef struct packed {
    scan_mode_e mode;
    logic [1:0] quote_run;
    logic       star_seen;
  } scan_ctl_t;

  typedef struct packed {
    status_e     status;
    token_kind_e kind;
  } scan_res_t;

  function automatic logic is_nl(logic [CpW-1:0] c);
    return (c == CP_CR) || (c == CP_LF) || (c == CP_NEL) || (c == CP_FF) ||
           (c == CP_LS) || (c == CP_PS);
  endfunction

endpackage

// ----- src/rsncl_step.sv -----
module rsncl_step import rsncl_pkg::*; #(
  parameter int unsigned     MaxHashes = MAX_HASHES,
  parameter longint unsigned MaxDepth  = MAX_DEPTH,
  parameter int              HashW     = $clog2(MaxHashes + 1),
  parameter int              DepthW    = $clog2(64'(MaxDepth) + 64'd1)
) (
  input  logic [CpW-1:0]    code_point_i,
  input  logic              start_req_i,
  input  logic [2:0]        allowed_tokens_i,
  input  scan_ctl_t         ctl_i,
  input  logic [HashW-1:0]  open_hashes_i,
  input  logic [HashW-1:0]  matched_hashes_i,
  input  logic [DepthW-1:0] depth_i,
  output scan_ctl_t         ctl_o,
  output logic [HashW-1:0]  open_hashes_o,
  output logic [HashW-1:0]  matched_hashes_o,
  output logic [DepthW-1:0] depth_o,
  output scan_res_t         res_o
);

  logic [CpW-1:0]    c;
  scan_ctl_t         ctl;
  logic [HashW-1:0]  openh;
  logic [HashW-1:0]  matched;
  logic [DepthW-1:0] depth;
  scan_res_t         res;
  logic              hit_close;

  assign c = code_point_i;

  always_comb begin
    ctl       = ctl_i;
    openh     = open_hashes_i;
    matched   = matched_hashes_i;
    depth     = depth_i;
    res       = '{status: ST_CONT, kind: TK_END};
    hit_close = (matched_hashes_i + HashW'(1)) >= open_hashes_i;

    if (start_req_i) begin
      if (c == CP_EOF && allowed_tokens_i[MaskEnd]) begin
        res = '{status: ST_ACCEPT, kind: TK_END};
      end else if (allowed_tokens_i[MaskRaw] && c == CP_HASH) begin
        openh    = HashW'(1);
        ctl.mode = M_R_HASH;
      end else if (allowed_tokens_i[MaskComment] && c == CP_SLASH) begin
        ctl.mode = M_C_OPEN;
      end else begin
        res.status = ST_REJECT;
      end
    end else begin
      unique case (ctl_i.mode)
        M_C_OPEN: begin
          if (c != CP_STAR) begin
            res.status = ST_REJECT;
          end else begin
            depth         = DepthW'(1);
            ctl.star_seen = 1'b0;
            ctl.mode      = M_C_BODY;
          end
        end
        M_C_BODY: begin
          if (c == CP_EOF) begin
            res.status = ST_REJECT;
          end else if (c == CP_STAR) begin
            ctl.star_seen = 1'b1;
          end else if (c == CP_SLASH) begin
            if (ctl_i.star_seen) begin
              ctl.star_seen = 1'b0;
              depth         = depth_i - DepthW'(1);
              if (depth_i == DepthW'(1)) begin
                res = '{status: ST_ACCEPT, kind: TK_COMMENT};
              end
            end else begin
              ctl.mode = M_C_SLASH;
            end
          end else begin
            ctl.star_seen = 1'b0;
          end
        end
        M_C_SLASH: begin
          if (c == CP_STAR) begin
            if (depth_i >= DepthW'(MaxDepth)) begin
              res.status = ST_REJECT;
            end else begin
              depth         = depth_i + DepthW'(1);
              ctl.star_seen = 1'b0;
              ctl.mode      = M_C_BODY;
            end
          end else if (c == CP_EOF) begin
            res.status = ST_REJECT;
          end else if (c == CP_SLASH) begin
            ctl.mode = M_C_SLASH;
          end else begin
            ctl.star_seen = 1'b0;
            ctl.mode      = M_C_BODY;
          end
        end
        M_R_HASH: begin
          if (c == CP_HASH) begin
            if (open_hashes_i >= HashW'(MaxHashes)) begin
              res.status = ST_REJECT;
            end else begin
              openh = open_hashes_i + HashW'(1);
            end
          end else if (c == CP_QUOTE) begin
            ctl.mode = M_R_Q1;
          end else begin
            res.status = ST_REJECT;
          end
        end
        M_R_Q1: begin
          if (c == CP_QUOTE) begin
            ctl.mode = M_R_Q2;
          end else if (c == CP_EOF || is_nl(c)) begin
            res.status = ST_REJECT;
          end else begin
            ctl.mode = M_R_SL;
          end
        end
        M_R_Q2: begin
          if (c == CP_QUOTE) begin
            ctl.mode = M_R_ML_NL;
          end else if (c == CP_HASH) begin
            matched  = HashW'(1);
            ctl.mode = M_R_EMPTY;
            if (HashW'(1) >= open_hashes_i) begin
              res = '{status: ST_ACCEPT, kind: TK_RAW};
            end
          end else begin
            res.status = ST_REJECT;
          end
        end
        M_R_EMPTY: begin
          if (c == CP_HASH) begin
            matched = matched_hashes_i + HashW'(1);
            if (hit_close) begin
              res = '{status: ST_ACCEPT, kind: TK_RAW};
            end
          end else begin
            res.status = ST_REJECT;
          end
        end
        M_R_SL_CLOSE: begin
          if (c == CP_HASH) begin
            matched = matched_hashes_i + HashW'(1);
            if (hit_close) begin
              res = '{status: ST_ACCEPT, kind: TK_RAW};
            end
          end else if (c == CP_EOF || is_nl(c)) begin
            res.status = ST_REJECT;
          end else if (c == CP_QUOTE) begin
            matched  = '0;
            ctl.mode = M_R_SL_CLOSE;
          end else begin
            ctl.mode = M_R_SL;
          end
        end
        M_R_ML_CLOSE: begin
          if (c == CP_HASH) begin
            matched = matched_hashes_i + HashW'(1);
            if (hit_close) begin
              res = '{status: ST_ACCEPT, kind: TK_RAW};
            end
          end else if (c == CP_EOF) begin
            res.status = ST_REJECT;
          end else if (c == CP_QUOTE) begin
            ctl.quote_run = 2'd1;
            ctl.mode      = M_R_ML_QUOTES;
          end else begin
            ctl.mode = M_R_ML;
          end
        end
        M_R_ML_NL: begin
          if (!is_nl(c)) begin
            res.status = ST_REJECT;
          end else begin
            ctl.mode = M_R_ML;
          end
        end
        M_R_SL: begin
          if (c == CP_EOF || is_nl(c)) begin
            res.status = ST_REJECT;
          end else if (c == CP_QUOTE) begin
            matched  = '0;
            ctl.mode = M_R_SL_CLOSE;
          end
        end
        M_R_ML: begin
          if (c == CP_EOF) begin
            res.status = ST_REJECT;
          end else if (c == CP_QUOTE) begin
            ctl.quote_run = 2'd1;
            ctl.mode      = M_R_ML_QUOTES;
          end
        end
        M_R_ML_QUOTES: begin
          if (c == CP_QUOTE) begin
            if (ctl_i.quote_run >= 2'd2) begin
              ctl.quote_run = 2'd0;
              matched       = '0;
              ctl.mode      = M_R_ML_CLOSE;
            end else begin
              ctl.quote_run = ctl_i.quote_run + 2'd1;
            end
          end else if (c == CP_EOF) begin
            res.status = ST_REJECT;
          end else begin
            ctl.quote_run = 2'd0;
            ctl.mode      = M_R_ML;
          end
        end
        default: begin
          res.status = ST_REJECT;
        end
      endcase
    end

    // scan ends on accept or reject
    if (res.status != ST_CONT) begin
      ctl     = '{mode: M_IDLE, quote_run: 2'd0, star_seen: 1'b0};
      openh   = '0;
      matched = '0;
      depth   = '0;
    end
  end

  assign ctl_o            = ctl;
  assign open_hashes_o    = openh;
  assign matched_hashes_o = matched;
  assign depth_o          = depth;
  assign res_o            = res;

endmodule

// ----- src/raw_string_nested_comment_lexer.sv -----
// Path: each code point passes through the input register and then the result register,
// which loads when no stalled result occupies it.
// Throughput: one code point per cycle unless out_stall_i holds a result; the scan state
// updates in a single combinational step between the input register and the result register.
// Reset: asynchronous, active low; clears both valid flags and returns the
// scan to idle with all counters at zero.
module raw_string_nested_comment_lexer import rsncl_pkg::*; #(
  parameter int unsigned     MaxHashes = MAX_HASHES,
  parameter longint unsigned MaxDepth  = MAX_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [CpW-1:0] code_point_i,
  input  logic           start_req_i,
  input  logic [2:0]     allowed_tokens_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     status_o,
  output logic [1:0]     token_kind_o
);

  localparam int HashW  = $clog2(MaxHashes + 1);
  localparam int DepthW = $clog2(64'(MaxDepth) + 64'd1);

  logic              in_valid_q;
  logic [CpW-1:0]    cp_q;
  logic              start_q;
  logic [2:0]        mask_q;

  scan_ctl_t         ctl_q, ctl_d;
  logic [HashW-1:0]  open_q, open_d;
  logic [HashW-1:0]  matched_q, matched_d;
  logic [DepthW-1:0] depth_q, depth_d;

  logic              out_valid_q;
  scan_res_t         res_q, res_d;

  logic              fire;
  logic              load;

  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign load       = !in_valid_q || fire;
  assign in_stall_o = !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      cp_q    <= code_point_i;
      start_q <= start_req_i;
      mask_q  <= allowed_tokens_i;
    end
  end

  rsncl_step #(
    .MaxHashes (MaxHashes),
    .MaxDepth  (MaxDepth),
    .HashW     (HashW),
    .DepthW    (DepthW)
  ) u_step (
    .code_point_i     (cp_q),
    .start_req_i      (start_q),
    .allowed_tokens_i (mask_q),
    .ctl_i            (ctl_q),
    .open_hashes_i    (open_q),
    .matched_hashes_i (matched_q),
    .depth_i          (depth_q),
    .ctl_o            (ctl_d),
    .open_hashes_o    (open_d),
    .matched_hashes_o (matched_d),
    .depth_o          (depth_d),
    .res_o            (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q     <= '{mode: M_IDLE, quote_run: 2'd0, star_seen: 1'b0};
      open_q    <= '0;
      matched_q <= '0;
      depth_q   <= '0;
    end else if (fire) begin
      ctl_q     <= ctl_d;
      open_q    <= open_d;
      matched_q <= matched_d;
      depth_q   <= depth_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = res_q.status;
  assign token_kind_o = res_q.kind;

endmodule
